// ===== design/sht_pkg.sv =====
package sht_pkg;

  // Table geometry.
  localparam int TABLE_SLOTS = 64;
  localparam int LAYER_COUNT = 16;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);

  // Command codes carried by a request word.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Shape kind codes.
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_BOX    = 2'd1;
  localparam logic [1:0] KIND_CIRCLE = 2'd2;
  localparam logic [1:0] KIND_POINT  = 2'd3;

  // Request word.
  typedef struct packed {
    logic               command;
    logic        [5:0]  slot;
    logic        [3:0]  layer_id;
    logic        [1:0]  shape_kind;
    logic signed [15:0] centre_x;
    logic signed [15:0] centre_y;
    logic        [14:0] size_x;
    logic        [14:0] size_y;
    logic        [14:0] radius;
    logic signed [15:0] probe_x;
    logic signed [15:0] probe_y;
  } req_t;

  // Response word.
  typedef struct packed {
    logic       hit;
    logic [5:0] hit_slot;
  } rsp_t;

  // One stored table entry.
  typedef struct packed {
    logic        [3:0]  layer;
    logic        [1:0]  kind;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic        [14:0] sx;
    logic        [14:0] sy;
    logic        [14:0] radius;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_we;
    logic query_start;
    logic scan_issue;
    logic flush;
    logic stage_zero;
    logic stage_scan;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic issue_last;
    logic res_live;
    logic res_hit;
    logic res_last;
  } dp_status_t;

endpackage

// ===== design/sht_ram.sv =====
module sht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sht_ctrl.sv =====
module sht_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic                req_command,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  sht_pkg::dp_status_t status,
  output sht_pkg::ctrl_cmd_t  cmd
);

  import sht_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_WAIT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   res_done;

  assign out_free = !rsp_valid || rsp_ready;
  // The scan ends at the first hit or when the last slot leaves the pipeline.
  assign res_done = status.res_live && (status.res_hit || status.res_last);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_command == CMD_LOAD) begin
            cmd.load_we    = 1'b1;
            cmd.stage_zero = 1'b1;
            state_next     = ST_WAIT;
          end else begin
            cmd.query_start = 1'b1;
            state_next      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (res_done) begin
          cmd.stage_scan = 1'b1;
          cmd.flush      = 1'b1;
          state_next     = ST_WAIT;
        end else begin
          cmd.scan_issue = 1'b1;
          if (status.issue_last) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (res_done) begin
          cmd.stage_scan = 1'b1;
          cmd.flush      = 1'b1;
          state_next     = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register and response valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/sht_datapath.sv =====
module sht_datapath (
  input  logic                clk,
  input  logic                rst,
  input  sht_pkg::req_t       req,
  input  sht_pkg::ctrl_cmd_t  cmd,
  output sht_pkg::dp_status_t status,
  output sht_pkg::rsp_t       rsp
);

  import sht_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  // Table valid bits and the entry store.
  logic [TABLE_SLOTS-1:0] valid;
  logic                   wr_en;
  logic [SLOT_W-1:0]      wr_addr;
  entry_t                 wr_entry;
  entry_t                 rd_entry;

  // Query registers and scan address.
  logic        [3:0]        q_layer;
  logic signed [15:0]       q_px;
  logic signed [15:0]       q_py;
  logic        [SLOT_W-1:0] addr;

  // Issue stage, aligned with the RAM read data.
  logic              i_live;
  logic [SLOT_W-1:0] i_slot;
  logic              i_valid;

  // Difference stage.
  logic               a_live;
  logic [SLOT_W-1:0]  a_slot;
  logic               a_match;
  logic [1:0]         a_kind;
  logic signed [16:0] a_dx;
  logic signed [16:0] a_dy;
  logic               a_box;
  logic               a_point;
  logic [14:0]        a_r;

  // Square stage.
  logic              b_live;
  logic [SLOT_W-1:0] b_slot;
  logic              b_pre;
  logic              b_circ;
  logic [31:0]       b_dx2;
  logic [31:0]       b_dy2;
  logic [29:0]       b_r2;

  // Compare stage.
  logic              c_live;
  logic [SLOT_W-1:0] c_slot;
  logic              c_hit;

  // Staged result waiting for the output register.
  logic       st_hit;
  logic [5:0] st_slot;

  // Combinational helpers of the difference, square and compare stages.
  logic signed [16:0] dx_c;
  logic signed [16:0] dy_c;
  logic signed [16:0] hx_s;
  logic signed [16:0] hy_s;
  logic signed [33:0] dx_sq;
  logic signed [33:0] dy_sq;
  logic        [32:0] dist2;

  // Loads outside the table or the layer range are dropped.
  assign wr_en   = cmd.load_we && (32'(req.slot) < TABLE_SLOTS)
                   && (32'(req.layer_id) < LAYER_COUNT);
  assign wr_addr = SLOT_W'(req.slot);

  always_comb begin
    wr_entry.layer  = req.layer_id;
    wr_entry.kind   = req.shape_kind;
    wr_entry.cx     = req.centre_x;
    wr_entry.cy     = req.centre_y;
    wr_entry.sx     = req.size_x;
    wr_entry.sy     = req.size_y;
    wr_entry.radius = req.radius;
  end

  sht_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_entry),
    .raddr(addr),
    .rdata(rd_entry)
  );

  // Offsets from the centre and the box half sizes.
  assign dx_c = {q_px[15], q_px} - {rd_entry.cx[15], rd_entry.cx};
  assign dy_c = {q_py[15], q_py} - {rd_entry.cy[15], rd_entry.cy};
  assign hx_s = {3'b000, rd_entry.sx[14:1]};
  assign hy_s = {3'b000, rd_entry.sy[14:1]};

  // Squares of the offsets; both magnitudes fit in 32 bits.
  assign dx_sq = a_dx * a_dx;
  assign dy_sq = a_dy * a_dy;
  assign dist2 = {1'b0, b_dx2} + {1'b0, b_dy2};

  // Status to the controller.
  assign status.issue_last = (addr == LAST_SLOT);
  assign status.res_live   = c_live;
  assign status.res_hit    = c_hit;
  assign status.res_last   = (c_slot == LAST_SLOT);

  // Control registers: valid bits and stage flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      i_live <= 1'b0;
      a_live <= 1'b0;
      b_live <= 1'b0;
      c_live <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (cmd.flush) begin
        i_live <= 1'b0;
        a_live <= 1'b0;
        b_live <= 1'b0;
        c_live <= 1'b0;
      end else begin
        i_live <= cmd.scan_issue;
        a_live <= i_live;
        b_live <= a_live;
        c_live <= b_live;
      end
    end
  end

  // Query latch and scan address.
  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      q_layer <= req.layer_id;
      q_px    <= req.probe_x;
      q_py    <= req.probe_y;
      addr    <= '0;
    end else if (cmd.scan_issue) begin
      addr <= addr + 1'b1;
    end
    i_slot  <= addr;
    i_valid <= valid[addr];
  end

  // Difference stage: box and point tests need only the offsets.
  always_ff @(posedge clk) begin
    a_slot  <= i_slot;
    a_match <= i_valid && (rd_entry.layer == q_layer);
    a_kind  <= rd_entry.kind;
    a_dx    <= dx_c;
    a_dy    <= dy_c;
    a_box   <= (dx_c > -hx_s) && (dx_c < hx_s) && (dy_c > -hy_s) && (dy_c < hy_s);
    a_point <= (dx_c == 17'sd0) && (dy_c == 17'sd0);
    a_r     <= rd_entry.radius;
  end

  // Square stage.
  always_ff @(posedge clk) begin
    b_slot <= a_slot;
    b_pre  <= a_match && (((a_kind == KIND_BOX) && a_box)
                          || ((a_kind == KIND_POINT) && a_point));
    b_circ <= a_match && (a_kind == KIND_CIRCLE);
    b_dx2  <= dx_sq[31:0];
    b_dy2  <= dy_sq[31:0];
    b_r2   <= a_r * a_r;
  end

  // Compare stage: the circle test closes here.
  always_ff @(posedge clk) begin
    c_slot <= b_slot;
    c_hit  <= b_pre || (b_circ && (dist2 < {3'b000, b_r2}));
  end

  // Staged result and output register.
  always_ff @(posedge clk) begin
    if (cmd.stage_zero) begin
      st_hit  <= 1'b0;
      st_slot <= '0;
    end else if (cmd.stage_scan) begin
      st_hit  <= c_hit;
      st_slot <= c_hit ? 6'(c_slot) : 6'd0;
    end
    if (cmd.out_load) begin
      rsp.hit      <= st_hit;
      rsp.hit_slot <= st_slot;
    end
  end

endmodule

// ===== design/shape_hit_test_table_core.sv =====
// Channel   Direction  Handshake              Word
// req       in         req_valid / req_ready  sht_pkg::req_t (load or query)
// rsp       out        rsp_valid / rsp_ready  sht_pkg::rsp_t (hit, hit_slot)
//
// A load is answered through the staging register into the output register; a
// query scans one slot per cycle through a four-stage compare pipeline and is
// answered once the last slot leaves the pipeline, sooner on an early hit.
// One word is in work at a time.
// Reset clears the slot valid bits at once; no clearing pass is needed. A
// stalled response holds while the next word runs into a staging register.
module shape_hit_test_table_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  sht_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output sht_pkg::rsp_t  rsp
);

  import sht_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  sht_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_command(req.command),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .status     (status),
    .cmd        (cmd)
  );

  sht_datapath u_dp (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .cmd   (cmd),
    .status(status),
    .rsp   (rsp)
  );

  // No request is taken while the compare pipeline carries a slot.
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (rst)
    status.res_live |-> !req_ready)
    else $error("request accepted during a scan");

  // The output register is only reloaded once its word has gone.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_valid || rsp_ready))
    else $error("response overwritten before it was taken");

  // A miss always reports slot zero.
  a_miss_slot: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.hit) |-> (rsp.hit_slot == 6'd0))
    else $error("miss reported with a non-zero slot");

  // A load never starts a scan in the following cycle.
  a_load_no_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.load_we |=> !cmd.scan_issue)
    else $error("scan issued after a load");

endmodule
